[hw/rtl/ppmdec_pkg.sv]
// Package for the PPM P6 stream decoder: byte codes, parser phases, result kinds,
// status codes, channel word types and output queue sizing.
// No dependencies; the decoder's modules import it.
package ppmdec_pkg;

   localparam int unsigned PPM_MAX_DIM = 4096;

   localparam int unsigned DIM_OUT_W = 13;
   localparam int unsigned ACC_W     = 16;
   localparam int unsigned BYTES_W   = 4;

   localparam logic [BYTES_W-1:0] MIN_BYTES = 4'd12;
   localparam logic [ACC_W-1:0]   ACC_MAX   = 16'hFFFF;
   localparam logic [ACC_W-1:0]   MAXVAL    = 16'd255;
   localparam logic [7:0]         ALPHA     = 8'hFF;

   localparam logic [7:0] CH_P    = 8'h50;
   localparam logic [7:0] CH_6    = 8'h36;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_SP   = 8'h20;
   localparam logic [7:0] CH_TAB  = 8'h09;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_0    = 8'h30;
   localparam logic [7:0] CH_9    = 8'h39;

   localparam int unsigned RSP_DEPTH = 8;
   localparam int unsigned RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int unsigned RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef enum logic [3:0] {
      PH_MAG0,
      PH_MAG1,
      PH_SKIP_W,
      PH_NUM_W,
      PH_TAIL_W,
      PH_SKIP_H,
      PH_NUM_H,
      PH_TAIL_H,
      PH_SKIP_M,
      PH_NUM_M,
      PH_TAIL_M,
      PH_PIX,
      PH_DONE,
      PH_ERR
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PIXEL,
      KIND_HEADER,
      KIND_END
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_SHORT_STREAM,
      ST_BAD_MAGIC,
      ST_BAD_MAXVAL,
      ST_SHORT_DATA,
      ST_TOO_LARGE
   } status_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      kind_type               kind;
      logic [31:0]            pixel;
      logic [DIM_OUT_W-1:0]   width;
      logic [DIM_OUT_W-1:0]   height;
      status_type             status;
      logic                   last;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0]      count;
      rsp_payload_type word0;
      rsp_payload_type word1;
   } rsp_push_type;

endpackage

[hw/rtl/ppmdec_stream_if.sv]
// Valid/ready channel carrying one word of a chosen payload type.
// Standalone; payload types come from ppmdec_pkg at the instantiation.
interface ppmdec_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/ppm_p6_stream_decoder.sv]
// Top level of the PPM P6 stream decoder: parser plus result queue.
// Depends on ppmdec_pkg, ppmdec_stream_if, ppmdec_parser, ppmdec_rsp_fifo.
//
//   channel  dir  word               one word is
//   req_ch   in   req_payload_type   one file byte, last_byte on the final one
//   rsp_ch   out  rsp_payload_type   a pixel, the header, or the end with status
//
// One byte accepted per cycle while req_ch.ready is high; its results pass through
// the parser's input word register and then the result queue before rsp_ch.
// A byte yields up to two words (pixel or header, then end on the last byte).
// req_ch.ready falls while the result queue has fewer than two free slots
// beyond those held for the byte in flight; rsp_ch stalls never drop words.
// Synchronous reset clears control state; no clearing pass.
module ppm_p6_stream_decoder #(
   parameter int unsigned MAX_DIM = ppmdec_pkg::PPM_MAX_DIM
) (
   input logic             clock,
   input logic             reset,
   ppmdec_stream_if.sink   req_ch,
   ppmdec_stream_if.source rsp_ch
);
   import ppmdec_pkg::*;

   logic                 accept;
   logic                 pending;
   rsp_push_type         push;
   logic [RSP_CNT_W-1:0] fill;
   logic [RSP_CNT_W:0]   demand;
   rsp_payload_type      out_word;
   logic                 out_valid;

   assign demand       = {1'b0, fill} + (pending ? (RSP_CNT_W+1)'(2) : '0);
   assign req_ch.ready = (demand <= (RSP_CNT_W+1)'(RSP_DEPTH - 2));
   assign accept       = req_ch.valid && req_ch.ready;

   ppmdec_parser #(
      .MAX_DIM (MAX_DIM)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .word    (req_ch.payload),
      .pending (pending),
      .push    (push)
   );

   ppmdec_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_ch.ready),
      .out_valid (out_valid),
      .out_word  (out_word),
      .fill      (fill)
   );

   assign rsp_ch.valid   = out_valid;
   assign rsp_ch.payload = out_word;

endmodule

[hw/rtl/ppmdec_parser.sv]
// Header parser and pixel packer: input word register, parse state and the
// per-byte next-state logic that produces up to two result words.
// Depends on ppmdec_pkg.
module ppmdec_parser #(
   parameter int unsigned MAX_DIM = ppmdec_pkg::PPM_MAX_DIM
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  ppmdec_pkg::req_payload_type word,
   output logic                        pending,
   output ppmdec_pkg::rsp_push_type    push
);
   import ppmdec_pkg::*;

   localparam int unsigned DIM_W   = $clog2(MAX_DIM + 1);
   localparam int unsigned STORE_W = (DIM_W > DIM_OUT_W) ? DIM_W : DIM_OUT_W;
   localparam int unsigned AREA_W  =
      $clog2(64'(MAX_DIM) * 64'(MAX_DIM) + 64'd1);

   logic            in_valid_ff, in_valid_in;
   req_payload_type in_word_ff;

   phase_type            phase_ff, phase_in;
   logic                 comment_ff, comment_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [STORE_W-1:0]   width_ff, width_in;
   logic [STORE_W-1:0]   height_ff, height_in;
   logic [BYTES_W-1:0]   bytes_ff, bytes_in;
   logic [AREA_W-1:0]    left_ff, left_in;
   logic [1:0]           comp_ff, comp_in;
   logic [15:0]          held_ff, held_in;
   status_type           err_ff, err_in;

   logic [7:0]           b;
   logic                 is_digit, is_sp_lf, is_ws;
   logic                 do_num, num_w, num_h;
   logic [ACC_W-1:0]     num_base;
   logic [ACC_W+3:0]     num_next;
   logic                 header_now, pix_now;
   logic [2*DIM_W-1:0]   area_full;
   logic [AREA_W-1:0]    area;
   logic [AREA_W-1:0]    left_dec;
   status_type           end_status;
   rsp_payload_type      first_word, end_word;

   assign in_valid_in = accept;
   assign pending     = in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_word_ff <= word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_MAG0;
         comment_ff <= 1'b0;
         acc_ff     <= '0;
         width_ff   <= '0;
         height_ff  <= '0;
         bytes_ff   <= '0;
         left_ff    <= '0;
         comp_ff    <= '0;
         held_ff    <= '0;
         err_ff     <= ST_OK;
      end else begin
         phase_ff   <= phase_in;
         comment_ff <= comment_in;
         acc_ff     <= acc_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         bytes_ff   <= bytes_in;
         left_ff    <= left_in;
         comp_ff    <= comp_in;
         held_ff    <= held_in;
         err_ff     <= err_in;
      end
   end

   assign b        = in_word_ff.byte_value;
   assign is_digit = (b >= CH_0) && (b <= CH_9);
   assign is_sp_lf = (b == CH_SP) || (b == CH_LF);
   assign is_ws    = is_sp_lf || (b == CH_TAB) || (b == CH_CR);
   assign num_w    = (phase_ff == PH_SKIP_W) || (phase_ff == PH_NUM_W);
   assign num_h    = (phase_ff == PH_SKIP_H) || (phase_ff == PH_NUM_H);
   assign num_next = {4'b0000, num_base} * 20'd10 + 20'(4'(b - CH_0));
   assign left_dec = left_ff - AREA_W'(1);

   always_comb begin
      phase_in   = phase_ff;
      comment_in = comment_ff;
      acc_in     = acc_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      bytes_in   = bytes_ff;
      left_in    = left_ff;
      comp_in    = comp_ff;
      held_in    = held_ff;
      err_in     = err_ff;
      do_num     = 1'b0;
      num_base   = acc_ff;
      header_now = 1'b0;
      pix_now    = 1'b0;
      area_full  = width_in[DIM_W-1:0] * height_in[DIM_W-1:0];
      area       = AREA_W'(area_full);
      end_status = ST_OK;

      if (in_valid_ff) begin
         if (bytes_ff < MIN_BYTES) begin
            bytes_in = bytes_ff + BYTES_W'(1);
         end

         case (phase_ff)
            PH_MAG0: begin
               if (b == CH_P) begin
                  phase_in = PH_MAG1;
               end else begin
                  phase_in = PH_ERR;
                  err_in   = ST_BAD_MAGIC;
               end
            end
            PH_MAG1: begin
               if (b == CH_6) begin
                  phase_in = PH_SKIP_W;
               end else begin
                  phase_in = PH_ERR;
                  err_in   = ST_BAD_MAGIC;
               end
            end
            PH_SKIP_W, PH_SKIP_H, PH_SKIP_M: begin
               if (comment_ff) begin
                  if (b == CH_LF) begin
                     comment_in = 1'b0;
                  end
               end else if (is_ws) begin
                  comment_in = 1'b0;
               end else if (b == CH_HASH) begin
                  comment_in = 1'b1;
               end else begin
                  do_num   = 1'b1;
                  num_base = '0;
               end
            end
            PH_NUM_W, PH_NUM_H, PH_NUM_M: begin
               do_num = 1'b1;
            end
            PH_TAIL_W: begin
               if (is_sp_lf) begin
                  phase_in = PH_SKIP_H;
               end
            end
            PH_TAIL_H: begin
               if (is_sp_lf) begin
                  phase_in = PH_SKIP_M;
               end
            end
            PH_TAIL_M: begin
               if (b == CH_LF) begin
                  header_now = 1'b1;
               end
            end
            PH_PIX: begin
               case (comp_ff)
                  2'd0: begin
                     held_in = {b, 8'h00};
                     comp_in = 2'd1;
                  end
                  2'd1: begin
                     held_in = {held_ff[15:8], b};
                     comp_in = 2'd2;
                  end
                  default: begin
                     pix_now = 1'b1;
                     comp_in = 2'd0;
                     left_in = left_dec;
                     if (left_dec == '0) begin
                        phase_in = PH_DONE;
                     end
                  end
               endcase
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase

         if (do_num) begin
            acc_in = num_base;
            if (is_digit) begin
               acc_in = (num_next > 20'(ACC_MAX)) ? ACC_MAX : num_next[ACC_W-1:0];
               if (num_w) begin
                  phase_in = PH_NUM_W;
               end else if (num_h) begin
                  phase_in = PH_NUM_H;
               end else begin
                  phase_in = PH_NUM_M;
               end
            end else if (num_w || num_h) begin
               if (num_w) begin
                  width_in = STORE_W'(num_base);
               end else begin
                  height_in = STORE_W'(num_base);
               end
               if (num_base > ACC_W'(MAX_DIM)) begin
                  phase_in = PH_ERR;
                  err_in   = ST_TOO_LARGE;
               end else if (num_w) begin
                  phase_in = is_sp_lf ? PH_SKIP_H : PH_TAIL_W;
               end else begin
                  phase_in = is_sp_lf ? PH_SKIP_M : PH_TAIL_H;
               end
            end else if (num_base != MAXVAL) begin
               phase_in = PH_ERR;
               err_in   = ST_BAD_MAXVAL;
            end else if (b == CH_LF) begin
               header_now = 1'b1;
            end else begin
               phase_in = PH_TAIL_M;
            end
         end

         if (header_now) begin
            left_in  = area;
            comp_in  = 2'd0;
            phase_in = (area != '0) ? PH_PIX : PH_DONE;
         end

         if (bytes_in < MIN_BYTES) begin
            end_status = ST_SHORT_STREAM;
         end else if (err_in != ST_OK) begin
            end_status = err_in;
         end else if (phase_in == PH_DONE) begin
            end_status = ST_OK;
         end else if ((phase_in == PH_PIX) || (phase_in == PH_TAIL_M)) begin
            end_status = ST_SHORT_DATA;
         end else if ((phase_in == PH_NUM_M) && (acc_in == MAXVAL)) begin
            end_status = ST_SHORT_DATA;
         end else begin
            end_status = ST_BAD_MAXVAL;
         end
      end

      first_word        = '0;
      first_word.kind   = pix_now ? KIND_PIXEL : KIND_HEADER;
      first_word.status = ST_OK;
      if (pix_now) begin
         first_word.pixel = {ALPHA, held_ff, b};
      end else begin
         first_word.width  = DIM_OUT_W'(width_in);
         first_word.height = DIM_OUT_W'(height_in);
      end

      end_word        = '0;
      end_word.kind   = KIND_END;
      end_word.status = end_status;
      end_word.last   = 1'b1;
      if (end_status != ST_SHORT_STREAM) begin
         end_word.width  = DIM_OUT_W'(width_in);
         end_word.height = DIM_OUT_W'(height_in);
      end

      push       = '0;
      push.word0 = first_word;
      push.word1 = end_word;
      if (in_valid_ff) begin
         if (pix_now || header_now) begin
            push.count = in_word_ff.last_byte ? 2'd2 : 2'd1;
         end else if (in_word_ff.last_byte) begin
            push.count = 2'd1;
            push.word0 = end_word;
         end
      end

      if (in_valid_ff && in_word_ff.last_byte) begin
         phase_in   = PH_MAG0;
         comment_in = 1'b0;
         acc_in     = '0;
         width_in   = '0;
         height_in  = '0;
         bytes_in   = '0;
         left_in    = '0;
         comp_in    = '0;
         held_in    = '0;
         err_in     = ST_OK;
      end
   end

endmodule

[hw/rtl/ppmdec_rsp_fifo.sv]
// Result queue: takes up to two words per cycle, hands out one per cycle while pop is high.
// Depends on ppmdec_pkg.
module ppmdec_rsp_fifo (
   input  logic                            clock,
   input  logic                            reset,
   input  ppmdec_pkg::rsp_push_type        push,
   input  logic                            pop,
   output logic                            out_valid,
   output ppmdec_pkg::rsp_payload_type     out_word,
   output logic [ppmdec_pkg::RSP_CNT_W-1:0] fill
);
   import ppmdec_pkg::*;

   rsp_payload_type      entries_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic [RSP_PTR_W-1:0] wr_ptr_nx;
   logic                 do_pop;

   assign out_valid = (count_ff != '0);
   assign out_word  = entries_ff[rd_ptr_ff];
   assign fill      = count_ff;
   assign do_pop    = pop && out_valid;
   assign wr_ptr_nx = wr_ptr_ff + RSP_PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(do_pop);
      count_in  = count_ff + RSP_CNT_W'(push.count) - RSP_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.word0;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_ptr_nx] <= push.word1;
      end
   end

endmodule

[hw/rtl/ppmdec_checker.sv]
// Port-level checks on the decoder's result channel, bound to the top level.
// Depends on ppmdec_pkg and ppm_p6_stream_decoder.
module ppmdec_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [31:0] rsp_pixel,
   input logic [12:0] rsp_width,
   input logic [12:0] rsp_height,
   input logic [2:0]  rsp_status,
   input logic        rsp_last
);
   import ppmdec_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_pixel)
         && $stable(rsp_status) && $stable(rsp_last))
      else $error("result word changed while stalled");

   a_last_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_kind == KIND_END)))
      else $error("last flag does not match end word");

   a_pixel_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_PIXEL) |-> (rsp_pixel[31:24] == ALPHA))
      else $error("pixel word not opaque");

   a_short_dims: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_END) && (rsp_status == ST_SHORT_STREAM)
         |-> (rsp_width == '0) && (rsp_height == '0))
      else $error("short stream end word carries dimensions");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind ppm_p6_stream_decoder ppmdec_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_kind   (rsp_ch.payload.kind),
   .rsp_pixel  (rsp_ch.payload.pixel),
   .rsp_width  (rsp_ch.payload.width),
   .rsp_height (rsp_ch.payload.height),
   .rsp_status (rsp_ch.payload.status),
   .rsp_last   (rsp_ch.payload.last)
);
